FILE: sv/jsu_pkg.sv
package jsu_pkg;

   // Parser position within the quoted string.
   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_BODY = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX1 = 3'd3,
      PH_HEX2 = 3'd4,
      PH_HEX3 = 3'd5,
      PH_HEX4 = 3'd6,
      PH_DONE = 3'd7
   } phase_type;

   // Kind of each result word.
   typedef enum logic [2:0] {
      ST_DATA     = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_NOQUOTE  = 3'd2,
      ST_BADESC   = 3'd3,
      ST_BADHEX   = 3'd4,
      ST_UNTERM   = 3'd5
   } status_type;

   // A decoded hex digit and whether the byte was one.
   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   localparam int unsigned MaxResults = 4;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [7:0] CODE_BS   = 8'h08;
   localparam logic [7:0] CODE_FF   = 8'h0C;
   localparam logic [7:0] CODE_LF   = 8'h0A;
   localparam logic [7:0] CODE_CR   = 8'h0D;
   localparam logic [7:0] CODE_TAB  = 8'h09;

   localparam logic [15:0] UTF8_MAX1 = 16'h007F;
   localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;

   // Decodes one ASCII hex digit, either case.
   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h.ok  = 1'b1;
      h.val = b[3:0];
      if (b >= 8'h30 && b <= 8'h39) begin
         h.val = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         h.val = b[3:0] + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

FILE: sv/json_string_unescaper_unit.sv
// Channel | Direction | tdata         | tuser       | tlast
// req_    | in        | [7:0] in_byte | -           | end_of_input
// rsp_    | out       | [7:0] out_byte| [2:0] status| last_of_run
//
// One input word is decoded per cycle; while the receiver takes every result, a word
// that gives one result or none sustains one word per cycle. A \u escape on its last
// digit gives up to three bytes, plus a status when the input also ends, and the
// result buffer then drains one word per cycle, as the receiver takes them, before the next word moves on.
// Reset returns the parser to waiting for the opening quote and empties both
// stages. A stalled result holds; one more input word waits in the input stage.
module json_string_unescaper_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [2:0] status
   output logic       rsp_tlast
);

   // Input stage.
   logic             in_vld_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   // Parser state.
   jsu_pkg::phase_type phase_ff, phase_in, phase_step;
   logic [11:0]      accum_ff, accum_in;

   // Result buffer, drained from entry 0.
   logic [7:0]       res_byte_ff   [jsu_pkg::MaxResults];
   logic [2:0]       res_status_ff [jsu_pkg::MaxResults];
   logic [2:0]       res_left_ff;
   logic [7:0]       res_byte_in   [jsu_pkg::MaxResults];
   logic [2:0]       res_status_in [jsu_pkg::MaxResults];
   logic [2:0]       res_left_in;

   // Decode outputs.
   logic [7:0]       data_byte [jsu_pkg::MaxResults];
   logic [1:0]       data_cnt;
   logic             stat_en;
   jsu_pkg::status_type stat_code;
   jsu_pkg::hex_type hex;
   logic [15:0]      code_point;

   logic             pop;
   logic             move;

   assign pop        = rsp_tvalid && rsp_tready;
   assign move       = in_vld_ff && ((res_left_ff == 3'd0) || (res_left_ff == 3'd1 && pop));
   assign req_tready = !in_vld_ff || move;

   assign hex        = jsu_pkg::hex_digit(in_byte_ff);
   assign code_point = {accum_ff, hex.val};

   // Next parser phase and hex accumulator.
   always_comb begin
      phase_step = phase_ff;
      accum_in   = accum_ff;
      unique case (phase_ff)
         jsu_pkg::PH_WAIT: begin
            phase_step = (in_byte_ff == jsu_pkg::CH_QUOTE) ? jsu_pkg::PH_BODY
                                                           : jsu_pkg::PH_DONE;
         end
         jsu_pkg::PH_BODY: begin
            if (in_byte_ff == jsu_pkg::CH_QUOTE) begin
               phase_step = jsu_pkg::PH_DONE;
            end else if (in_byte_ff == jsu_pkg::CH_BSLASH) begin
               phase_step = jsu_pkg::PH_ESC;
            end
         end
         jsu_pkg::PH_ESC: begin
            case (in_byte_ff)
               jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
               jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R,
               jsu_pkg::CH_T: phase_step = jsu_pkg::PH_BODY;
               jsu_pkg::CH_U: begin
                  phase_step = jsu_pkg::PH_HEX1;
                  accum_in   = '0;
               end
               default: phase_step = jsu_pkg::PH_DONE;
            endcase
         end
         jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
            if (hex.ok) begin
               accum_in   = code_point[11:0];
               phase_step = jsu_pkg::phase_type'(phase_ff + 3'd1);
            end else begin
               phase_step = jsu_pkg::PH_DONE;
            end
         end
         jsu_pkg::PH_HEX4: begin
            phase_step = hex.ok ? jsu_pkg::PH_BODY : jsu_pkg::PH_DONE;
         end
         jsu_pkg::PH_DONE: phase_step = jsu_pkg::PH_DONE;
         default:          phase_step = jsu_pkg::PH_DONE;
      endcase
      // Input that ends with the string still open closes it.
      phase_in = (in_last_ff && phase_step != jsu_pkg::PH_DONE) ? jsu_pkg::PH_DONE
                                                                : phase_step;
   end

   // Result words caused by the word in the input stage.
   always_comb begin
      data_byte[0] = in_byte_ff;
      data_byte[1] = '0;
      data_byte[2] = '0;
      data_byte[3] = '0;
      data_cnt     = 2'd0;
      stat_en      = 1'b0;
      stat_code    = jsu_pkg::ST_DATA;
      unique case (phase_ff)
         jsu_pkg::PH_WAIT: begin
            if (in_byte_ff != jsu_pkg::CH_QUOTE) begin
               stat_en   = 1'b1;
               stat_code = jsu_pkg::ST_NOQUOTE;
            end
         end
         jsu_pkg::PH_BODY: begin
            if (in_byte_ff == jsu_pkg::CH_QUOTE) begin
               stat_en   = 1'b1;
               stat_code = jsu_pkg::ST_COMPLETE;
            end else if (in_byte_ff != jsu_pkg::CH_BSLASH) begin
               data_cnt = 2'd1;
            end
         end
         jsu_pkg::PH_ESC: begin
            data_cnt = 2'd1;
            case (in_byte_ff)
               jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                  data_byte[0] = in_byte_ff;
               jsu_pkg::CH_B: data_byte[0] = jsu_pkg::CODE_BS;
               jsu_pkg::CH_F: data_byte[0] = jsu_pkg::CODE_FF;
               jsu_pkg::CH_N: data_byte[0] = jsu_pkg::CODE_LF;
               jsu_pkg::CH_R: data_byte[0] = jsu_pkg::CODE_CR;
               jsu_pkg::CH_T: data_byte[0] = jsu_pkg::CODE_TAB;
               jsu_pkg::CH_U: data_cnt = 2'd0;
               default: begin
                  data_cnt  = 2'd0;
                  stat_en   = 1'b1;
                  stat_code = jsu_pkg::ST_BADESC;
               end
            endcase
         end
         jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
            if (!hex.ok) begin
               stat_en   = 1'b1;
               stat_code = jsu_pkg::ST_BADHEX;
            end
         end
         jsu_pkg::PH_HEX4: begin
            if (!hex.ok) begin
               stat_en   = 1'b1;
               stat_code = jsu_pkg::ST_BADHEX;
            end else if (code_point <= jsu_pkg::UTF8_MAX1) begin
               data_cnt     = 2'd1;
               data_byte[0] = code_point[7:0];
            end else if (code_point <= jsu_pkg::UTF8_MAX2) begin
               data_cnt     = 2'd2;
               data_byte[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, code_point[10:6]};
               data_byte[1] = jsu_pkg::UTF8_CONT | {2'b00, code_point[5:0]};
            end else begin
               data_cnt     = 2'd3;
               data_byte[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, code_point[15:12]};
               data_byte[1] = jsu_pkg::UTF8_CONT | {2'b00, code_point[11:6]};
               data_byte[2] = jsu_pkg::UTF8_CONT | {2'b00, code_point[5:0]};
            end
         end
         jsu_pkg::PH_DONE: data_cnt = 2'd0;
         default:          data_cnt = 2'd0;
      endcase
      // Unterminated string: status follows the data bytes.
      if (!stat_en && in_last_ff && phase_step != jsu_pkg::PH_DONE) begin
         stat_en   = 1'b1;
         stat_code = jsu_pkg::ST_UNTERM;
      end
   end

   // Next contents of the result buffer.
   always_comb begin
      for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
         res_byte_in[i]   = res_byte_ff[i];
         res_status_in[i] = res_status_ff[i];
      end
      res_left_in = res_left_ff;
      if (move) begin
         for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
            if (2'(i) < data_cnt) begin
               res_byte_in[i]   = data_byte[i];
               res_status_in[i] = jsu_pkg::ST_DATA;
            end else begin
               res_byte_in[i]   = '0;
               res_status_in[i] = stat_code;
            end
         end
         res_left_in = {1'b0, data_cnt} + {2'b00, stat_en};
      end else if (pop) begin
         for (int i = 0; i < jsu_pkg::MaxResults - 1; i++) begin
            res_byte_in[i]   = res_byte_ff[i + 1];
            res_status_in[i] = res_status_ff[i + 1];
         end
         res_left_in = res_left_ff - 3'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         phase_ff    <= jsu_pkg::PH_WAIT;
         accum_ff    <= '0;
         res_left_ff <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (move) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
         end
         res_left_ff <= res_left_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
         res_byte_ff[i]   <= res_byte_in[i];
         res_status_ff[i] <= res_status_in[i];
      end
   end

   assign rsp_tvalid = (res_left_ff != 3'd0);
   assign rsp_tdata  = res_byte_ff[0];
   assign rsp_tuser  = res_status_ff[0];
   assign rsp_tlast  = (res_left_ff == 3'd1);

endmodule

FILE: sv/jsu_checker.sv
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   // Set once a status word other than data has been taken.
   logic finished_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         finished_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready &&
                   rsp_tuser != 3'(jsu_pkg::ST_DATA)) begin
         finished_ff <= 1'b1;
      end
   end

   // A stalled result word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Status words carry a zero byte and always close their run.
   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != 3'(jsu_pkg::ST_DATA) |-> rsp_tdata == 8'h00 && rsp_tlast)
      else $error("status word with data or not last");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= 3'(jsu_pkg::ST_UNTERM))
      else $error("undefined status code");

   // Once the string has ended nothing more comes out.
   a_silent_after_end: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !rsp_tvalid)
      else $error("result after final status");

   // The input side does not stay stalled while the result buffer is empty.
   a_input_moves: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tvalid && !req_tready |=> req_tready)
      else $error("input stalled with empty output");

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: tb/json_unescape_checker.sv
`timescale 1ns / 100ps

module json_unescape_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] out_byte
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        rsp_tlast,
   output int unsigned mismatch_count,
   output int unsigned words_pending
);

   localparam logic [7:0] ASCII_0       = 8'h30;
   localparam logic [7:0] ASCII_9       = 8'h39;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_F = 8'h46;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_F = 8'h66;

   // One decoded result word as the block should present it.
   typedef struct packed {
      logic [7:0]          data;
      jsu_pkg::status_type status;
      logic                last;
   } decoded_word_type;

   decoded_word_type   decoded_q[$];
   jsu_pkg::phase_type parse_phase = jsu_pkg::PH_WAIT;
   logic [15:0]        code_point  = '0;
   int unsigned        mismatches  = 0;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic expect_word(input logic [7:0] data, input jsu_pkg::status_type status);
      decoded_q.push_back('{data: data, status: status, last: 1'b0});
   endtask

   // Returns {valid, nibble} for an ASCII hex digit of either case.
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      logic [7:0] diff;
      diff = '0;
      if (b >= ASCII_0 && b <= ASCII_9) begin
         diff = b - ASCII_0;
      end else if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_F) begin
         diff = b - ASCII_UPPER_A + 8'd10;
      end else if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_F) begin
         diff = b - ASCII_LOWER_A + 8'd10;
      end else begin
         return 5'b0;
      end
      return {1'b1, diff[3:0]};
   endfunction

   // Advances the parser by one input word and queues the words it causes.
   task automatic decode_step(input logic [7:0] b, input logic end_of_input);
      int unsigned first;
      logic [4:0]  nib;
      first = decoded_q.size();
      nib   = hex_nibble(b);
      case (parse_phase)
         jsu_pkg::PH_WAIT: begin
            if (b == jsu_pkg::CH_QUOTE) begin
               parse_phase = jsu_pkg::PH_BODY;
            end else begin
               expect_word(8'h00, jsu_pkg::ST_NOQUOTE);
               parse_phase = jsu_pkg::PH_DONE;
            end
         end
         jsu_pkg::PH_BODY: begin
            if (b == jsu_pkg::CH_QUOTE) begin
               expect_word(8'h00, jsu_pkg::ST_COMPLETE);
               parse_phase = jsu_pkg::PH_DONE;
            end else if (b == jsu_pkg::CH_BSLASH) begin
               parse_phase = jsu_pkg::PH_ESC;
            end else begin
               expect_word(b, jsu_pkg::ST_DATA);
            end
         end
         jsu_pkg::PH_ESC: begin
            parse_phase = jsu_pkg::PH_BODY;
            case (b)
               jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                  expect_word(b, jsu_pkg::ST_DATA);
               jsu_pkg::CH_B: expect_word(jsu_pkg::CODE_BS, jsu_pkg::ST_DATA);
               jsu_pkg::CH_F: expect_word(jsu_pkg::CODE_FF, jsu_pkg::ST_DATA);
               jsu_pkg::CH_N: expect_word(jsu_pkg::CODE_LF, jsu_pkg::ST_DATA);
               jsu_pkg::CH_R: expect_word(jsu_pkg::CODE_CR, jsu_pkg::ST_DATA);
               jsu_pkg::CH_T: expect_word(jsu_pkg::CODE_TAB, jsu_pkg::ST_DATA);
               jsu_pkg::CH_U: begin
                  code_point  = '0;
                  parse_phase = jsu_pkg::PH_HEX1;
               end
               default: begin
                  expect_word(8'h00, jsu_pkg::ST_BADESC);
                  parse_phase = jsu_pkg::PH_DONE;
               end
            endcase
         end
         jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4: begin
            if (!nib[4]) begin
               expect_word(8'h00, jsu_pkg::ST_BADHEX);
               parse_phase = jsu_pkg::PH_DONE;
            end else begin
               code_point = {code_point[11:0], nib[3:0]};
               if (parse_phase != jsu_pkg::PH_HEX4) begin
                  parse_phase = jsu_pkg::phase_type'(parse_phase + 3'd1);
               end else begin
                  // UTF-8 encoding in one, two or three bytes.
                  parse_phase = jsu_pkg::PH_BODY;
                  if (code_point <= jsu_pkg::UTF8_MAX1) begin
                     expect_word(code_point[7:0], jsu_pkg::ST_DATA);
                  end else if (code_point <= jsu_pkg::UTF8_MAX2) begin
                     expect_word(jsu_pkg::UTF8_LEAD2 | {3'b0, code_point[10:6]},
                                 jsu_pkg::ST_DATA);
                     expect_word(jsu_pkg::UTF8_CONT | {2'b0, code_point[5:0]},
                                 jsu_pkg::ST_DATA);
                  end else begin
                     expect_word(jsu_pkg::UTF8_LEAD3 | {4'b0, code_point[15:12]},
                                 jsu_pkg::ST_DATA);
                     expect_word(jsu_pkg::UTF8_CONT | {2'b0, code_point[11:6]},
                                 jsu_pkg::ST_DATA);
                     expect_word(jsu_pkg::UTF8_CONT | {2'b0, code_point[5:0]},
                                 jsu_pkg::ST_DATA);
                  end
               end
            end
         end
         default: ;
      endcase

      // Input that ends while the string is still open.
      if (end_of_input && parse_phase != jsu_pkg::PH_DONE) begin
         expect_word(8'h00, jsu_pkg::ST_UNTERM);
         parse_phase = jsu_pkg::PH_DONE;
      end
      if (decoded_q.size() > first) begin
         decoded_q[decoded_q.size() - 1].last = 1'b1;
      end
   endtask

   // Predict on accepted input words, compare accepted result words.
   always @(posedge clock) begin
      decoded_word_type want;
      if (reset) begin
         parse_phase = jsu_pkg::PH_WAIT;
         code_point  = '0;
         decoded_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_step(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected word data=%h status=%0d last=%b",
                                         rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tdata !== want.data) begin
                  report_mismatch($sformatf("data %h, expected %h", rsp_tdata, want.data));
               end
               if (rsp_tuser !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_tuser, want.status.name()));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("last %b, expected %b", rsp_tlast, want.last));
               end
            end
         end
      end
      mismatch_count <= mismatches;
      words_pending  <= decoded_q.size();
   end

endmodule

FILE: tb/tb_json_string_unescaper_unit.sv
`timescale 1ns / 100ps

module tb_json_string_unescaper_unit;

   localparam int unsigned BodyWords    = 180;
   localparam int unsigned SettleCycles = 8;
   localparam int unsigned CycleLimit   = 200000;

   localparam logic [7:0] ASCII_0       = 8'h30;
   localparam logic [7:0] ASCII_9       = 8'h39;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_F = 8'h46;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_F = 8'h66;

   // Ways the one string of a run can come to an end.
   typedef enum int {
      END_QUOTE,
      END_BAD_ESCAPE,
      END_BAD_HEX,
      END_EOI_PLAIN,
      END_EOI_ESCAPE,
      END_EOI_UNICODE,
      END_EOI_INSIDE_ESCAPE,
      END_NO_QUOTE,
      END_EOI_ON_OPEN
   } ending_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] in_byte
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [7:0] out_byte
   logic [2:0]  rsp_tuser;            // [2:0] status
   logic        rsp_tlast;

   int unsigned mismatch_count;
   int unsigned words_pending;
   int unsigned send_gap_pct = 26;
   int unsigned recv_gap_pct = 63;
   int unsigned cycle_count  = 0;

   logic [7:0]  text_q[$];
   logic        eoi_q[$];
   logic [7:0]  escape_letters[8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                      jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                                      jsu_pkg::CH_F, jsu_pkg::CH_N,
                                      jsu_pkg::CH_R, jsu_pkg::CH_T};
   logic [15:0] directed_codes[12] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                       16'h0800, 16'hFFFF, 16'hD800, 16'hDFFF,
                                       16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0};

   json_string_unescaper_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   json_unescape_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("FAIL json_string_unescaper_unit");
         $finish;
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      if (nib < 4'd10) begin
         return ASCII_0 + {4'h0, nib};
      end
      return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + {4'h0, nib} - 8'd10;
   endfunction

   // Any byte that stays inside the string body as plain data.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
      return b;
   endfunction

   function automatic logic [15:0] random_code_point();
      case ($urandom_range(4))
         0: return 16'($urandom_range(16'h007F));
         1: return 16'($urandom_range(16'h07FF, 16'h0080));
         2: return 16'($urandom_range(16'hFFFF, 16'h0800));
         3: return 16'($urandom_range(16'hDFFF, 16'hD800));
         default: return directed_codes[4'($urandom_range(11))];
      endcase
   endfunction

   task automatic add_word(input logic [7:0] b, input logic eoi);
      text_q.push_back(b);
      eoi_q.push_back(eoi);
   endtask

   // A \u escape, digits in random case; the end flag rides on the last digit.
   task automatic add_unicode(input logic [15:0] cp, input logic eoi);
      add_word(jsu_pkg::CH_BSLASH, 1'b0);
      add_word(jsu_pkg::CH_U, 1'b0);
      for (int i = 3; i >= 0; i--) begin
         add_word(hex_char(cp[i*4 +: 4], 1'($urandom_range(1))), (i == 0) ? eoi : 1'b0);
      end
   endtask

   // Offers one word and holds it until the block takes it.
   task automatic send_word(input logic [7:0] b, input logic eoi);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      int unsigned pick;
      int unsigned depth;
      int unsigned total;
      ending_type  ending;
      logic [7:0]  b;

      // Only one string fits in a run, so the way it ends is drawn first.
      pick = $urandom_range(31);
      if (pick == 31) begin
         ending = END_NO_QUOTE;
      end else if (pick == 30) begin
         ending = END_EOI_ON_OPEN;
      end else begin
         ending = ending_type'(pick % 7);
      end

      if (ending == END_NO_QUOTE) begin
         do b = 8'($urandom_range(255)); while (b == jsu_pkg::CH_QUOTE);
         add_word(b, 1'($urandom_range(1)));
      end else if (ending == END_EOI_ON_OPEN) begin
         add_word(jsu_pkg::CH_QUOTE, 1'b1);
      end else begin
         // Directed opening: byte extremes, every escape, UTF-8 size edges.
         add_word(jsu_pkg::CH_QUOTE, 1'b0);
         add_word(8'h00, 1'b0);
         add_word(8'hFF, 1'b0);
         add_word(8'h7F, 1'b0);
         add_word(8'h80, 1'b0);
         add_word(jsu_pkg::CODE_LF, 1'b0);
         foreach (escape_letters[i]) begin
            add_word(jsu_pkg::CH_BSLASH, 1'b0);
            add_word(escape_letters[i], 1'b0);
         end
         foreach (directed_codes[i]) begin
            add_unicode(directed_codes[i], 1'b0);
         end

         // Random well-formed body.
         while (text_q.size() < BodyWords) begin
            pick = $urandom_range(9);
            if (pick < 5) begin
               add_word(plain_byte(), 1'b0);
            end else if (pick < 7) begin
               add_word(jsu_pkg::CH_BSLASH, 1'b0);
               add_word(escape_letters[3'($urandom_range(7))], 1'b0);
            end else begin
               add_unicode(random_code_point(), 1'b0);
            end
         end

         // The string's end.
         case (ending)
            END_QUOTE: begin
               add_word(jsu_pkg::CH_QUOTE, 1'($urandom_range(1)));
            end
            END_BAD_ESCAPE: begin
               add_word(jsu_pkg::CH_BSLASH, 1'b0);
               do b = 8'($urandom_range(255));
               while (b == jsu_pkg::CH_U ||
                      b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                                jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                                jsu_pkg::CH_R, jsu_pkg::CH_T});
               add_word(b, 1'($urandom_range(1)));
            end
            END_BAD_HEX: begin
               add_word(jsu_pkg::CH_BSLASH, 1'b0);
               add_word(jsu_pkg::CH_U, 1'b0);
               repeat ($urandom_range(3)) begin
                  add_word(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
               end
               do b = 8'($urandom_range(255));
               while (b inside {[ASCII_0:ASCII_9], [ASCII_UPPER_A:ASCII_UPPER_F],
                                [ASCII_LOWER_A:ASCII_LOWER_F]});
               add_word(b, 1'($urandom_range(1)));
            end
            END_EOI_PLAIN: begin
               add_word(plain_byte(), 1'b1);
            end
            END_EOI_ESCAPE: begin
               add_word(jsu_pkg::CH_BSLASH, 1'b0);
               add_word(escape_letters[3'($urandom_range(7))], 1'b1);
            end
            END_EOI_UNICODE: begin
               add_unicode(16'($urandom_range(16'hFFFF, 16'h0800)), 1'b1);
            end
            default: begin
               // Input ends after the backslash, after the u, or mid-digits.
               depth = $urandom_range(4);
               add_word(jsu_pkg::CH_BSLASH, depth == 0);
               if (depth > 0) begin
                  add_word(jsu_pkg::CH_U, depth == 1);
               end
               for (int i = 2; i <= depth; i++) begin
                  add_word(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))),
                           i == depth);
               end
            end
         endcase
      end

      // Bytes after the end must be swallowed without results.
      repeat ($urandom_range(8, 3)) begin
         add_word(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      // A string that ends early is followed by enough ignored bytes to keep
      // the run length similar.
      while (text_q.size() < BodyWords) begin
         add_word(8'($urandom_range(255)), 1'($urandom_range(1)));
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Three idling regimes over the stream.
      total = text_q.size();
      foreach (text_q[i]) begin
         if (i < total / 3) begin
            send_gap_pct = 26;
            recv_gap_pct = 63;
         end else if (i < 2 * total / 3) begin
            send_gap_pct = 63;
            recv_gap_pct = 26;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         send_word(text_q[i], eoi_q[i]);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (words_pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS json_string_unescaper_unit");
      end else begin
         $display("FAIL json_string_unescaper_unit");
      end
      $finish;
   end

endmodule
